/* hw/rtl/imuae_pkg.sv */
`timescale 1ns / 1ps
package imuae_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int MAX_STAGES        = 24;
	localparam int NUM_OFFSETS       = 6;
	localparam int VXW               = 52;
	localparam int RXW               = 27;
	localparam int ZW                = 28;
	localparam int G_Q12             = 40141;
	localparam int GAIN_Q24          = 10188014;
	localparam int HALF_PI_Q12       = 6434;
	localparam logic [24:0] TP_RECIP = 25'((64'd1 << 40) / 64'd40141);

	typedef enum logic [2:0] {
		REG_ACCEL_X_OFF = 3'd0,
		REG_ACCEL_Y_OFF = 3'd1,
		REG_ACCEL_Z_OFF = 3'd2,
		REG_GYRO_X_OFF  = 3'd3,
		REG_GYRO_Y_OFF  = 3'd4,
		REG_GYRO_Z_OFF  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [23:0] ax;
		logic signed [23:0] ay;
		logic signed [23:0] az;
		logic signed [23:0] gx;
		logic signed [23:0] gy;
		logic signed [23:0] gz;
		logic               sat;
		logic signed [24:0] tp;
	} side_t;

	function automatic logic [23:0] atan_tab(input int unsigned i);
		logic [23:0] r;
		unique case (i)
			0: r = 24'd13176795;
			1: r = 24'd7778716;
			2: r = 24'd4110060;
			3: r = 24'd2086331;
			4: r = 24'd1047214;
			5: r = 24'd524117;
			6: r = 24'd262123;
			7: r = 24'd131069;
			8: r = 24'd65536;
			9: r = 24'd32768;
			10: r = 24'd16384;
			11: r = 24'd8192;
			12: r = 24'd4096;
			13: r = 24'd2048;
			14: r = 24'd1024;
			15: r = 24'd512;
			16: r = 24'd256;
			17: r = 24'd128;
			18: r = 24'd64;
			19: r = 24'd32;
			20: r = 24'd16;
			21: r = 24'd8;
			22: r = 24'd4;
			23: r = 24'd2;
			default: r = 24'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
		logic signed [23:0] r;
		if (v > 40'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -40'sd8388608) begin
			r = -24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	function automatic logic clip24(input logic signed [39:0] v);
		return (v > 40'sd8388607) || (v < -40'sd8388608);
	endfunction

	function automatic logic signed [13:0] angle_q12(input logic signed [ZW-1:0] z);
		logic signed [ZW-1:0] r;
		logic signed [13:0]   a;
		r = (z + ZW'(2048)) >>> 12;
		if (r > ZW'(HALF_PI_Q12)) begin
			a = 14'(HALF_PI_Q12);
		end else if (r < -ZW'(HALF_PI_Q12)) begin
			a = -14'(HALF_PI_Q12);
		end else begin
			a = r[13:0];
		end
		return a;
	endfunction

endpackage

/* hw/rtl/imuae_if.sv */
`timescale 1ns / 1ps
interface imuae_cfg_if;
	logic              valid;
	logic              ready;
	logic [2:0]        reg_index;
	logic signed [23:0] data;
	modport source (output valid, reg_index, data, input ready);
	modport sink (input valid, reg_index, data, output ready);
endinterface

interface imuae_sample_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] accel_x;
	logic signed [23:0] accel_y;
	logic signed [23:0] accel_z;
	logic signed [23:0] gyro_x;
	logic signed [23:0] gyro_y;
	logic signed [23:0] gyro_z;
	modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		output ready);
endinterface

interface imuae_result_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] corrected_accel_x;
	logic signed [23:0] corrected_accel_y;
	logic signed [23:0] corrected_accel_z;
	logic signed [23:0] corrected_gyro_x;
	logic signed [23:0] corrected_gyro_y;
	logic signed [23:0] corrected_gyro_z;
	logic signed [13:0] bank_angle;
	logic signed [13:0] elev_angle;
	logic signed [23:0] bank_rate;
	logic signed [23:0] elev_rate;
	logic               saturated;
	modport source (output valid, corrected_accel_x, corrected_accel_y, corrected_accel_z,
		corrected_gyro_x, corrected_gyro_y, corrected_gyro_z, bank_angle, elev_angle,
		bank_rate, elev_rate, saturated, input ready);
	modport sink (input valid, corrected_accel_x, corrected_accel_y, corrected_accel_z,
		corrected_gyro_x, corrected_gyro_y, corrected_gyro_z, bank_angle, elev_angle,
		bank_rate, elev_rate, saturated, output ready);
endinterface

/* hw/rtl/imuae_cordic_cell.sv */
`timescale 1ns / 1ps
module imuae_cordic_cell import imuae_pkg::*; #(
	parameter int   STAGE  = 0,
	parameter int   XW     = VXW,
	parameter logic VECTOR = 1'b1
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [XW-1:0] x_i,
	input  logic signed [XW-1:0] y_i,
	input  logic signed [ZW-1:0] z_i,
	output logic signed [XW-1:0] x_o,
	output logic signed [XW-1:0] y_o,
	output logic signed [ZW-1:0] z_o
);

	logic signed [XW-1:0] x_q, y_q, dx, dy;
	logic signed [ZW-1:0] z_q, at;
	logic                 pos;

	// vectoring drives y to zero, rotation drives z to zero
	assign pos = VECTOR ? y_i[XW-1] : !z_i[ZW-1];
	assign dx  = y_i >>> STAGE;
	assign dy  = x_i >>> STAGE;
	assign at  = ZW'(atan_tab(STAGE));

	always_ff @(posedge clk) begin
		if (en) begin
			if (pos) begin
				x_q <= x_i - dx;
				y_q <= y_i + dy;
				z_q <= z_i - at;
			end else begin
				x_q <= x_i + dx;
				y_q <= y_i - dy;
				z_q <= z_i + at;
			end
		end
	end

	assign x_o = x_q;
	assign y_o = y_q;
	assign z_o = z_q;

endmodule

/* hw/rtl/imu_attitude_and_euler_rates_core.sv */
`timescale 1ns / 1ps
// throughput: one sample per cycle while not stalled; offset removal, two vectoring
// chains, one rotation chain and the rate multipliers all move one stage per cycle
// a result waiting at the output stalls the whole pipeline
// reset clears the offsets to zero and empties the pipeline
module imu_attitude_and_euler_rates_core import imuae_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	imuae_cfg_if.sink      cfg,
	imuae_sample_if.sink   sample,
	imuae_result_if.source result
);

	localparam int N = CORDIC_STAGES;

	logic en;
	logic signed [23:0] off_q [NUM_OFFSETS];
	logic signed [23:0] in_v [NUM_OFFSETS];

	assign en = !result.valid || result.ready;
	assign sample.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_OFFSETS; i++) off_q[i] <= '0;
		end else if (cfg.valid && cfg.ready && cfg.reg_index <= REG_GYRO_Z_OFF) begin
			off_q[cfg.reg_index] <= cfg.data;
		end
	end

	assign in_v[0] = sample.accel_x;
	assign in_v[1] = sample.accel_y;
	assign in_v[2] = sample.accel_z;
	assign in_v[3] = sample.gyro_x;
	assign in_v[4] = sample.gyro_y;
	assign in_v[5] = sample.gyro_z;

	// offset removal
	logic signed [23:0] v_s1 [NUM_OFFSETS];
	logic               sat_s1;
	logic signed [24:0] diff [NUM_OFFSETS];
	logic [NUM_OFFSETS-1:0] clip;

	always_comb begin
		for (int i = 0; i < NUM_OFFSETS; i++) begin
			diff[i] = {in_v[i][23], in_v[i]} - {off_q[i][23], off_q[i]};
			clip[i] = clip24(40'(diff[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_OFFSETS; i++) v_s1[i] <= sat24(40'(diff[i]));
			sat_s1 <= |clip;
		end
	end

	// tan pitch = ax / g by reciprocal multiply and one correction
	side_t        sd_s2, sd_s3, sd_s4, sd_n;
	logic [23:0]  mag_s2, mag_s3, q0_s3;
	logic         neg_s2, neg_s3;
	logic [48:0]  prod_s2;
	logic [39:0]  chk_s3, rem;
	logic [24:0]  q_fix;
	logic [23:0]  mag_n;

	assign mag_n = v_s1[0][23] ? 24'(-v_s1[0]) : 24'(v_s1[0]);

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s2 <= '{ax: v_s1[0], ay: v_s1[1], az: v_s1[2], gx: v_s1[3], gy: v_s1[4],
				gz: v_s1[5], sat: sat_s1, tp: '0};
			mag_s2  <= mag_n;
			neg_s2  <= v_s1[0][23];
			prod_s2 <= mag_n * TP_RECIP;
			sd_s3   <= sd_s2;
			mag_s3  <= mag_s2;
			neg_s3  <= neg_s2;
			q0_s3   <= prod_s2[47:24];
			chk_s3  <= prod_s2[47:24] * 16'(G_Q12);
		end
	end

	assign rem   = {mag_s3, 16'b0} - chk_s3;
	assign q_fix = {1'b0, q0_s3} + 25'(rem >= 40'(G_Q12));

	always_comb begin
		sd_n    = sd_s3;
		sd_n.tp = neg_s3 ? -q_fix : q_fix;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s4 <= sd_n;
		end
	end

	// vectoring chains for roll and pitch
	logic signed [VXW-1:0] rvx [N+1];
	logic signed [VXW-1:0] rvy [N+1];
	logic signed [ZW-1:0]  rvz [N+1];
	logic signed [VXW-1:0] pvx [N+1];
	logic signed [VXW-1:0] pvy [N+1];
	logic signed [ZW-1:0]  pvz [N+1];
	side_t                 side_v [N+1];
	logic signed [24:0]    ay_e, az_e, ay_abs, ry_v;

	assign ay_e   = {sd_s4.ay[23], sd_s4.ay};
	assign az_e   = {sd_s4.az[23], sd_s4.az};
	assign ay_abs = sd_s4.ay[23] ? -ay_e : ay_e;
	assign ry_v   = sd_s4.ay[23] ? -az_e : az_e;
	assign rvx[0] = {{3{ay_abs[24]}}, ay_abs, 24'b0};
	assign rvy[0] = {{3{ry_v[24]}}, ry_v, 24'b0};
	assign rvz[0] = '0;
	assign pvx[0] = {4'b0, 24'(G_Q12), 24'b0};
	assign pvy[0] = {{4{sd_s4.ax[23]}}, sd_s4.ax, 24'b0};
	assign pvz[0] = '0;
	assign side_v[0] = sd_s4;

	for (genvar k = 0; k < N; k++) begin : g_vec
		imuae_cordic_cell #(.STAGE(k), .XW(VXW), .VECTOR(1'b1)) u_roll (
			.clk, .en, .x_i(rvx[k]), .y_i(rvy[k]), .z_i(rvz[k]),
			.x_o(rvx[k+1]), .y_o(rvy[k+1]), .z_o(rvz[k+1]));
		imuae_cordic_cell #(.STAGE(k), .XW(VXW), .VECTOR(1'b1)) u_pitch (
			.clk, .en, .x_i(pvx[k]), .y_i(pvy[k]), .z_i(pvz[k]),
			.x_o(pvx[k+1]), .y_o(pvy[k+1]), .z_o(pvz[k+1]));
		always_ff @(posedge clk) begin
			if (en) side_v[k+1] <= side_v[k];
		end
	end

	// angle rounding
	logic signed [13:0] roll_a, pitch_a;
	side_t              sd_a;

	always_ff @(posedge clk) begin
		if (en) begin
			roll_a  <= (side_v[N].ay == '0 && side_v[N].az == '0) ? '0 : angle_q12(rvz[N]);
			pitch_a <= angle_q12(pvz[N]);
			sd_a    <= side_v[N];
		end
	end

	// rotation chain for sin and cos of roll
	logic signed [RXW-1:0] cx [N+1];
	logic signed [RXW-1:0] cy [N+1];
	logic signed [ZW-1:0]  cz [N+1];
	side_t                 side_r [N+1];
	logic signed [13:0]    roll_r [N+1];
	logic signed [13:0]    pitch_r [N+1];

	assign cx[0] = RXW'(GAIN_Q24);
	assign cy[0] = '0;
	assign cz[0] = {{2{roll_a[13]}}, roll_a, 12'b0};
	assign side_r[0]  = sd_a;
	assign roll_r[0]  = roll_a;
	assign pitch_r[0] = pitch_a;

	for (genvar k = 0; k < N; k++) begin : g_rot
		imuae_cordic_cell #(.STAGE(k), .XW(RXW), .VECTOR(1'b0)) u_rot (
			.clk, .en, .x_i(cx[k]), .y_i(cy[k]), .z_i(cz[k]),
			.x_o(cx[k+1]), .y_o(cy[k+1]), .z_o(cz[k+1]));
		always_ff @(posedge clk) begin
			if (en) begin
				side_r[k+1]  <= side_r[k];
				roll_r[k+1]  <= roll_r[k];
				pitch_r[k+1] <= pitch_r[k];
			end
		end
	end

	// rate arithmetic
	logic signed [50:0] gys_m1, gzc_m1, gyc_m1, gzs_m1;
	side_t              sd_m1, sd_m2, sd_m3;
	logic signed [13:0] roll_m1, roll_m2, roll_m3, pitch_m1, pitch_m2, pitch_m3;
	logic signed [51:0] sum_w, dif_w;
	logic signed [25:0] inner_m2;
	logic signed [23:0] pr_m2, pr_m3;
	logic               prc_m2, prc_m3;
	logic signed [50:0] tprod_m3;
	logic signed [34:0] term;
	logic signed [39:0] rr_w;

	assign sum_w = (52'(gys_m1) + 52'(gzc_m1) + 52'sd8388608) >>> 24;
	assign dif_w = (52'(gyc_m1) - 52'(gzs_m1) + 52'sd8388608) >>> 24;
	assign term  = 35'((52'(tprod_m3) + 52'sd32768) >>> 16);
	assign rr_w  = 40'(sd_m3.gx) + 40'(term);

	always_ff @(posedge clk) begin
		if (en) begin
			gys_m1   <= side_r[N].gy * cy[N];
			gzc_m1   <= side_r[N].gz * cx[N];
			gyc_m1   <= side_r[N].gy * cx[N];
			gzs_m1   <= side_r[N].gz * cy[N];
			sd_m1    <= side_r[N];
			roll_m1  <= roll_r[N];
			pitch_m1 <= pitch_r[N];
			inner_m2 <= sum_w[25:0];
			pr_m2    <= sat24(dif_w[39:0]);
			prc_m2   <= clip24(dif_w[39:0]);
			sd_m2    <= sd_m1;
			roll_m2  <= roll_m1;
			pitch_m2 <= pitch_m1;
			tprod_m3 <= inner_m2 * sd_m2.tp;
			pr_m3    <= pr_m2;
			prc_m3   <= prc_m2;
			sd_m3    <= sd_m2;
			roll_m3  <= roll_m2;
			pitch_m3 <= pitch_m2;
		end
	end

	// output register
	side_t              sd_q;
	logic signed [13:0] roll_q, pitch_q;
	logic signed [23:0] rr_q, pr_q;
	logic               flag_q;

	always_ff @(posedge clk) begin
		if (en) begin
			sd_q    <= sd_m3;
			roll_q  <= roll_m3;
			pitch_q <= pitch_m3;
			rr_q    <= sat24(rr_w);
			pr_q    <= pr_m3;
			flag_q  <= sd_m3.sat || prc_m3 || clip24(rr_w);
		end
	end

	// valid bits
	localparam int DEPTH = 2 * N + 9;
	logic [DEPTH-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], sample.valid};
		end
	end

	assign result.valid             = vld_q[DEPTH-1];
	assign result.corrected_accel_x = sd_q.ax;
	assign result.corrected_accel_y = sd_q.ay;
	assign result.corrected_accel_z = sd_q.az;
	assign result.corrected_gyro_x  = sd_q.gx;
	assign result.corrected_gyro_y  = sd_q.gy;
	assign result.corrected_gyro_z  = sd_q.gz;
	assign result.bank_angle        = roll_q;
	assign result.elev_angle        = pitch_q;
	assign result.bank_rate         = rr_q;
	assign result.elev_rate         = pr_q;
	assign result.saturated         = flag_q;

endmodule

/* hw/rtl/imuae_checker.sv */
`timescale 1ns / 1ps
module imuae_checker import imuae_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [13:0] roll,
	input logic signed [13:0] pitch
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	a_roll: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (roll <= 14'(HALF_PI_Q12)) && (roll >= -14'(HALF_PI_Q12)))
		else $error("roll out of range");

	a_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch <= 14'(HALF_PI_Q12)) && (pitch >= -14'(HALF_PI_Q12)))
		else $error("pitch out of range");

endmodule

bind imu_attitude_and_euler_rates_core imuae_checker u_imuae_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.roll      (result.bank_angle),
	.pitch     (result.elev_angle)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top import imuae_pkg::*;;

	typedef struct {
		logic signed [23:0] cax, cay, caz, cgx, cgy, cgz;
		logic signed [13:0] roll, pitch;
		logic signed [23:0] rr, pr;
		logic               sat;
	} attitude_t;

	class attitude_scoreboard;
		longint offs[NUM_OFFSETS];
		attitude_t pending[$];
		int errors;

		function longint asr(longint v, int s);
			return v >>> s;
		endfunction

		function longint rnd(longint v, int s);
			return (v + (longint'(1) << (s - 1))) >>> s;
		endfunction

		function longint sat(longint v, ref bit flag);
			if (v > 8388607) begin
				flag = 1;
				return 8388607;
			end
			if (v < -8388608) begin
				flag = 1;
				return -8388608;
			end
			return v;
		endfunction

		function longint arctan_step(int i);
			longint t[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
				262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
				256, 128, 64, 32, 16, 8, 4, 2};
			return t[i];
		endfunction

		function longint heading(longint x, longint y);
			longint z, dx, dy;
			z = 0;
			x = x <<< 24;
			y = y <<< 24;
			for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
				dx = asr(y, i);
				dy = asr(x, i);
				if (y >= 0) begin
					x += dx; y -= dy; z += arctan_step(i);
				end else begin
					x -= dx; y += dy; z -= arctan_step(i);
				end
			end
			z = rnd(z, 12);
			if (z > HALF_PI_Q12) z = HALF_PI_Q12;
			if (z < -HALF_PI_Q12) z = -HALF_PI_Q12;
			return z;
		endfunction

		function void note_sample(longint a[6]);
			attitude_t e;
			longint v[6];
			longint roll, pitch, x, y, z, dx, dy, tp, inner, term;
			bit flag;
			flag = 0;
			for (int i = 0; i < 6; i++) v[i] = sat(a[i] - offs[i], flag);
			if (v[1] == 0 && v[2] == 0) roll = 0;
			else roll = heading(v[1] < 0 ? -v[1] : v[1], v[1] < 0 ? -v[2] : v[2]);
			pitch = heading(G_Q12, v[0]);
			x = GAIN_Q24;
			y = 0;
			z = roll * 4096;
			for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
				dx = asr(y, i);
				dy = asr(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= arctan_step(i);
				end else begin
					x += dx; y -= dy; z += arctan_step(i);
				end
			end
			tp = (v[0] * 65536) / G_Q12;
			inner = rnd(v[4] * y + v[5] * x, 24);
			term = rnd(inner * tp, 16);
			e.rr = 24'(sat(v[3] + term, flag));
			e.pr = 24'(sat(rnd(v[4] * x - v[5] * y, 24), flag));
			e.cax = 24'(v[0]); e.cay = 24'(v[1]); e.caz = 24'(v[2]);
			e.cgx = 24'(v[3]); e.cgy = 24'(v[4]); e.cgz = 24'(v[5]);
			e.roll = 14'(roll);
			e.pitch = 14'(pitch);
			e.sat = flag;
			pending.push_back(e);
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch %s: got %0d want %0d", what, got, want);
			errors++;
		endtask

		task check_result(attitude_t r);
			attitude_t e;
			if (pending.size() == 0) begin
				report("unexpected result", 1, 0);
				return;
			end
			e = pending.pop_front();
			if (r.cax !== e.cax) report("corrected_accel_x", r.cax, e.cax);
			if (r.cay !== e.cay) report("corrected_accel_y", r.cay, e.cay);
			if (r.caz !== e.caz) report("corrected_accel_z", r.caz, e.caz);
			if (r.cgx !== e.cgx) report("corrected_gyro_x", r.cgx, e.cgx);
			if (r.cgy !== e.cgy) report("corrected_gyro_y", r.cgy, e.cgy);
			if (r.cgz !== e.cgz) report("corrected_gyro_z", r.cgz, e.cgz);
			if (r.roll !== e.roll) report("bank_angle", r.roll, e.roll);
			if (r.pitch !== e.pitch) report("elev_angle", r.pitch, e.pitch);
			if (r.rr !== e.rr) report("bank_rate", r.rr, e.rr);
			if (r.pr !== e.pr) report("elev_rate", r.pr, e.pr);
			if (r.sat !== e.sat) report("saturated", r.sat, e.sat);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	bit calm = 0;
	imuae_cfg_if cfg ();
	imuae_sample_if sample ();
	imuae_result_if result ();
	attitude_scoreboard sb;

	imu_attitude_and_euler_rates_core u_dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .sample(sample), .result(result)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		cfg.valid = 0; cfg.reg_index = REG_ACCEL_X_OFF; cfg.data = 0;
		sample.valid = 0;
		sample.accel_x = 0; sample.accel_y = 0; sample.accel_z = 0;
		sample.gyro_x = 0; sample.gyro_y = 0; sample.gyro_z = 0;
		result.ready = 0;
	end

	always @(negedge clk) begin
		result.ready <= calm || ($urandom_range(99) >= 26);
	end

	always @(posedge clk) begin
		attitude_t r;
		if (arst_n && result.valid && result.ready) begin
			r.cax = result.corrected_accel_x; r.cay = result.corrected_accel_y;
			r.caz = result.corrected_accel_z; r.cgx = result.corrected_gyro_x;
			r.cgy = result.corrected_gyro_y; r.cgz = result.corrected_gyro_z;
			r.roll = result.bank_angle; r.pitch = result.elev_angle;
			r.rr = result.bank_rate; r.pr = result.elev_rate;
			r.sat = result.saturated;
			sb.check_result(r);
		end
	end

	task automatic write_offset(reg_idx_t idx, logic signed [23:0] val);
		@(negedge clk);
		cfg.valid <= 1;
		cfg.reg_index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		if (idx < NUM_OFFSETS) sb.offs[idx] = val;
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	task automatic write_stray_index();
		@(negedge clk);
		cfg.valid <= 1;
		cfg.reg_index <= 3'd6 + 3'($urandom_range(1));
		cfg.data <= 24'($urandom);
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	task automatic send_sample(longint a[6]);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 26) begin
			sample.valid <= 0;
			@(negedge clk);
		end
		sample.valid <= 1;
		sample.accel_x <= 24'(a[0]); sample.accel_y <= 24'(a[1]);
		sample.accel_z <= 24'(a[2]); sample.gyro_x <= 24'(a[3]);
		sample.gyro_y <= 24'(a[4]); sample.gyro_z <= 24'(a[5]);
		do @(posedge clk); while (!sample.ready);
		sb.note_sample(a);
	endtask

	task automatic drain();
		@(negedge clk);
		sample.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic longint pick_val();
		case ($urandom_range(5))
			0: return -8388608;
			1: return 8388607;
			2: return 0;
			3: return longint'($signed(24'($urandom)));
			default: return longint'($urandom_range(160000)) - 80000;
		endcase
	endfunction

	task automatic random_offsets();
		for (int i = 0; i < NUM_OFFSETS; i++)
			write_offset(reg_idx_t'(i), 24'($urandom_range(3) == 0 ?
				pick_val() : longint'($urandom_range(8000)) - 4000));
	endtask

	initial begin
		longint a[6];
		longint ext[6];
		sb = new();
		sb.errors = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		ext = '{-8388608, 8388607, 0, 1, -1, 40141};
		for (int k = 0; k < 6; k++) begin
			for (int i = 0; i < 6; i++) a[i] = ext[(k + i) % 6];
			send_sample(a);
		end
		send_sample('{0, 0, 0, 0, 0, 0});
		send_sample('{4096, 0, 5000, 100, 200, 300});
		send_sample('{-4096, 0, -5000, -100, 200, -300});
		send_sample('{40141, 4000, 0, 8388607, 8388607, 8388607});
		send_sample('{-40141, -4000, -3, -8388608, -8388608, 8388607});
		send_sample('{8388607, -8388608, 8388607, 1000, 8388607, -8388608});
		drain();

		for (int i = 0; i < NUM_OFFSETS; i++) write_offset(reg_idx_t'(i), 24'sh7FFFFF);
		write_stray_index();
		send_sample('{-8388608, -8388608, 0, -8388608, 1, 2});
		send_sample('{8388607, 8388607, 8388607, 8388607, 8388607, 8388607});
		drain();
		for (int i = 0; i < NUM_OFFSETS; i++) write_offset(reg_idx_t'(i), -24'sh800000);
		send_sample('{8388607, 8388607, 0, 8388607, 5, -5});
		send_sample('{-8388608, -1, -8388608, 0, 0, 0});
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			random_offsets();
			if (ph == 3) write_stray_index();
			calm = (ph == 2);
			for (int n = 0; n < 100; n++) begin
				for (int i = 0; i < 6; i++) a[i] = pick_val();
				if ($urandom_range(9) == 0) begin
					a[1] = sb.offs[1];
					if ($urandom_range(1)) a[2] = sb.offs[2];
				end
				send_sample(a);
			end
			calm = 0;
			drain();
		end

		if (sb.errors == 0) $display("tb_top: clean");
		else $display("tb_top: errors");
		$finish;
	end

	initial begin
		#3000000;
		$display("tb_top: errors");
		$finish;
	end
endmodule
